/* design/ajm_pkg.sv */
// ----------------------------------------------------------------------------
// ajm_pkg
// Shared types and constants of the accelerometer magnitude and jerk monitor.
// ----------------------------------------------------------------------------
package ajm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PERIOD_W   = 16;
  localparam int THR_W      = 8;
  localparam int MAG_W      = 16;
  localparam int JERK_W     = 25;
  localparam int FRAC_BITS  = 8;
  localparam int G_SHIFT    = 11;
  localparam int JERK_SCALE = 1000;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

  localparam int          SQ_CNT_W    = 3;
  localparam logic [2:0]  SQ_ACC_LAST = 3'd3;
  localparam logic [2:0]  SQ_ROOT     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MAG_SQ,
    ST_MAG_WAIT,
    ST_DIF_SQ,
    ST_DIF_WAIT,
    ST_OVR_A,
    ST_OVR_B,
    ST_DIV_WAIT,
    ST_FINISH
  } ajm_state_e;

  typedef struct packed {
    logic       load_in;
    logic       clear_hist;
    logic       take_fail;
    logic       set_sampled;
    logic       sq_diff;
    logic [1:0] sq_sel;
    logic       acc_clr;
    logic       mul_en;
    logic       acc_en;
    logic       sqrt_start;
    logic       store_mag;
    logic       store_root;
    logic       zero_jerk;
    logic       cmp_a;
    logic       cmp_b;
    logic       div_start;
    logic       store_jerk;
    logic       commit;
    logic       out_load;
  } ajm_cmd_t;

  typedef struct packed {
    logic enable;
    logic due;
    logic read_ok;
    logic hist;
    logic sqrt_busy;
    logic sqrt_done;
    logic div_done;
  } ajm_stat_t;

endpackage

/* design/ajm_if.sv */
// ----------------------------------------------------------------------------
// ajm_in_if / ajm_out_if
// Valid/ready channels carrying one sensor tick word and one result word.
// ----------------------------------------------------------------------------
interface ajm_in_if #(
  parameter int TIME_BITS   = 16,
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic        [TIME_BITS-1:0]   time_ms;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic signed [SAMPLE_BITS-1:0] raw_y;
  logic signed [SAMPLE_BITS-1:0] raw_z;
  logic                          read_ok;

  modport source (output valid, time_ms, raw_x, raw_y, raw_z, read_ok, input ready);
  modport sink   (input valid, time_ms, raw_x, raw_y, raw_z, read_ok, output ready);
endinterface

interface ajm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         sampled;
  logic                         read_failed;
  logic [ajm_pkg::MAG_W-1:0]    magnitude;
  logic [ajm_pkg::JERK_W-1:0]   jerk;
  logic                         over_threshold;

  modport source (output valid, sampled, read_failed, magnitude, jerk, over_threshold,
                  input ready);
  modport sink   (input valid, sampled, read_failed, magnitude, jerk, over_threshold,
                  output ready);
endinterface

/* design/accel_jerk_magnitude_monitor_unit.sv */
// ----------------------------------------------------------------------------
// accel_jerk_magnitude_monitor_unit
// Accelerometer vector magnitude and jerk threshold monitor, top level.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  in_if    in   valid/ready   time_ms, raw_x, raw_y, raw_z, read_ok
//  out_if   out  valid/ready   sampled, read_failed, magnitude, jerk, over_threshold
//  cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (enable, sample_period, threshold)
//
//  One word at a time. A tick that takes no good sample goes from decide to finish.
//  Good sample: square and root the magnitude; with history also square and root the
//  difference (shared bit-pair root unit run twice), then the bit-serial divider.
//  Reset returns config to its defaults and clears history at once; no clearing pass.
//  A stalled result holds in the output register; the next word waits, with the
//  sequencer in finish, only if the previous result is still pending at hand-off.
module accel_jerk_magnitude_monitor_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ajm_in_if.sink                          in_if,
  ajm_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [ajm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ajm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ajm_pkg::ajm_cmd_t   cmd;
  ajm_pkg::ajm_stat_t  stat;
  logic                in_ready;
  logic                out_valid;

  ajm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ajm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .time_ms_i        (in_if.time_ms),
    .raw_x_i          (in_if.raw_x),
    .raw_y_i          (in_if.raw_y),
    .raw_z_i          (in_if.raw_z),
    .read_ok_i        (in_if.read_ok),
    .sampled_o        (out_if.sampled),
    .read_failed_o    (out_if.read_failed),
    .magnitude_o      (out_if.magnitude),
    .jerk_o           (out_if.jerk),
    .over_threshold_o (out_if.over_threshold)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

endmodule

/* design/ajm_isqrt.sv */
// ----------------------------------------------------------------------------
// ajm_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ajm_isqrt #(
  parameter int W = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     radicand_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [W/2-1:0]   root_o
);

  localparam int R  = W / 2;
  localparam int CW = $clog2(R + 1);

  logic [W-1:0]   rad_q;
  logic [R+1:0]   rem_q;
  logic [R-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;

  logic [R+3:0]   rem_sh;
  logic [R+3:0]   trial;
  logic [R+3:0]   rem_n;
  logic           ge;

  assign rem_sh = {rem_q, rad_q[W-1:W-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_n  = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(R - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[W-3:0], 2'b00};
      rem_q  <= rem_n[R+1:0];
      root_q <= {root_q[R-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/ajm_div.sv */
// ----------------------------------------------------------------------------
// ajm_div
// Iterative restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ajm_div #(
  parameter int N = 25,
  parameter int D = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [N-1:0]  dividend_i,
  input  logic [D-1:0]  divisor_i,
  output logic          done_o,
  output logic [N-1:0]  quot_o
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]   qr_q;
  logic [D-1:0]   rem_q;
  logic [D-1:0]   dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;

  logic [D:0]     rem_sh;
  logic [D:0]     rem_n;
  logic           ge;

  assign rem_sh = {rem_q, qr_q[N-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_n  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qr_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      qr_q  <= {qr_q[N-2:0], ge};
      rem_q <= rem_n[D-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = qr_q;

endmodule

/* design/ajm_datapath.sv */
// ----------------------------------------------------------------------------
// ajm_datapath
// Config and history registers, squaring multiplier, root, divide, compare.
// ----------------------------------------------------------------------------
module ajm_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ajm_pkg::ajm_cmd_t                  cmd_i,
  output ajm_pkg::ajm_stat_t                 stat_o,
  input  logic                               cfg_we_i,
  input  logic [ajm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ajm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [TIME_BITS-1:0]               time_ms_i,
  input  logic [SAMPLE_BITS-1:0]             raw_x_i,
  input  logic [SAMPLE_BITS-1:0]             raw_y_i,
  input  logic [SAMPLE_BITS-1:0]             raw_z_i,
  input  logic                               read_ok_i,
  output logic                               sampled_o,
  output logic                               read_failed_o,
  output logic [ajm_pkg::MAG_W-1:0]          magnitude_o,
  output logic [ajm_pkg::JERK_W-1:0]         jerk_o,
  output logic                               over_threshold_o
);

  localparam int S      = SAMPLE_BITS;
  localparam int T      = TIME_BITS;
  localparam int SUM_W  = (2 * S + 2 > 64) ? 64 : 2 * S + 2;
  localparam int R      = SUM_W / 2;
  localparam int Q_W    = R + ajm_pkg::FRAC_BITS;
  localparam int LHS_W  = R + 10;
  localparam int TD_W   = T + ajm_pkg::THR_W;
  localparam int RHS_W  = TD_W + ajm_pkg::G_SHIFT;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int DUE_W  = (T > ajm_pkg::PERIOD_W) ? T : ajm_pkg::PERIOD_W;
  localparam int MAGX_W = R + ajm_pkg::MAG_W;
  localparam int JRKX_W = Q_W + ajm_pkg::JERK_W;

  // configuration
  logic                             en_q;
  logic [ajm_pkg::PERIOD_W-1:0]     period_q;
  logic [ajm_pkg::THR_W-1:0]        thr_q;

  // history and held results
  logic [T-1:0]                     last_time_q;
  logic [S-1:0]                     last_q [3];
  logic [ajm_pkg::MAG_W-1:0]        held_mag_q;
  logic [ajm_pkg::JERK_W-1:0]       held_jerk_q;
  logic                             held_over_q;

  // input word
  logic [T-1:0]                     t_q;
  logic [S-1:0]                     cur_q [3];
  logic                             ok_q;
  logic                             sampled_q;
  logic                             failed_q;

  // arithmetic
  logic [2*S-1:0]                   prod_q;
  logic [SUM_W-1:0]                 acc_q;
  logic [R-1:0]                     root_q;
  logic [TD_W-1:0]                  thrdt_q;

  // result word
  logic                             out_sampled_q;
  logic                             out_failed_q;
  logic [ajm_pkg::MAG_W-1:0]        out_mag_q;
  logic [ajm_pkg::JERK_W-1:0]       out_jerk_q;
  logic                             out_over_q;

  logic                             clr;
  logic [T-1:0]                     dt;
  logic [S-1:0]                     abs_cur [3];
  logic [S-1:0]                     abs_dif [3];
  logic [S:0]                       dif     [3];
  logic [S-1:0]                     op;
  logic [R-1:0]                     sq_root;
  logic                             sq_busy;
  logic                             sq_done;
  logic                             dv_done;
  logic [Q_W-1:0]                   quot;
  logic [MAGX_W-1:0]                mag_ext;
  logic [JRKX_W-1:0]                jerk_ext;
  logic [LHS_W-1:0]                 lhs;
  logic [RHS_W-1:0]                 rhs;

  assign clr = cmd_i.clear_hist ||
               (cfg_we_i && cfg_idx_i == ajm_pkg::CFG_ENABLE && !cfg_data_i[0]);

  assign dt = t_q - last_time_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_cur[i] = cur_q[i][S-1] ? (~cur_q[i] + 1'b1) : cur_q[i];
      dif[i]     = {cur_q[i][S-1], cur_q[i]} - {last_q[i][S-1], last_q[i]};
      abs_dif[i] = dif[i][S] ? S'(~dif[i] + 1'b1) : dif[i][S-1:0];
    end
  end

  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    op = cmd_i.sq_diff ? abs_dif[0] : abs_cur[0];
      2'd1:    op = cmd_i.sq_diff ? abs_dif[1] : abs_cur[1];
      2'd2:    op = cmd_i.sq_diff ? abs_dif[2] : abs_cur[2];
      default: op = '0;
    endcase
  end

  ajm_isqrt #(.W(SUM_W)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (acc_q),
    .busy_o     (sq_busy),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  ajm_div #(.N(Q_W), .D(T)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({root_q, {ajm_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (dt),
    .done_o     (dv_done),
    .quot_o     (quot)
  );

  assign mag_ext  = {{ajm_pkg::MAG_W{1'b0}}, sq_root};
  assign jerk_ext = {{ajm_pkg::JERK_W{1'b0}}, quot};
  assign lhs      = LHS_W'(root_q) * LHS_W'(ajm_pkg::JERK_SCALE);
  assign rhs      = {thrdt_q, {ajm_pkg::G_SHIFT{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      period_q    <= ajm_pkg::PERIOD_RESET;
      thr_q       <= '0;
      last_time_q <= '0;
      last_q[0]   <= '0;
      last_q[1]   <= '0;
      last_q[2]   <= '0;
      held_mag_q  <= '0;
      held_jerk_q <= '0;
      held_over_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ajm_pkg::CFG_ENABLE:    en_q     <= cfg_data_i[0];
          ajm_pkg::CFG_PERIOD:    period_q <= cfg_data_i;
          ajm_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[ajm_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (clr) begin
        last_time_q <= '0;
        last_q[0]   <= '0;
        last_q[1]   <= '0;
        last_q[2]   <= '0;
        held_mag_q  <= '0;
        held_jerk_q <= '0;
        held_over_q <= 1'b0;
      end else begin
        if (cmd_i.take_fail || cmd_i.commit) last_time_q <= t_q;
        if (cmd_i.commit) begin
          last_q[0] <= cur_q[0];
          last_q[1] <= cur_q[1];
          last_q[2] <= cur_q[2];
        end
        if (cmd_i.store_mag) held_mag_q <= mag_ext[ajm_pkg::MAG_W-1:0];
        if (cmd_i.zero_jerk) begin
          held_jerk_q <= '0;
          held_over_q <= 1'b0;
        end
        if (cmd_i.store_jerk) held_jerk_q <= jerk_ext[ajm_pkg::JERK_W-1:0];
        if (cmd_i.cmp_b) held_over_q <= CMP_W'(lhs) > CMP_W'(rhs);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t_q       <= time_ms_i;
      cur_q[0]  <= raw_x_i;
      cur_q[1]  <= raw_y_i;
      cur_q[2]  <= raw_z_i;
      ok_q      <= read_ok_i;
      sampled_q <= 1'b0;
      failed_q  <= 1'b0;
    end else begin
      if (cmd_i.take_fail)   failed_q  <= 1'b1;
      if (cmd_i.set_sampled) sampled_q <= 1'b1;
    end
    if (cmd_i.mul_en) prod_q <= {{S{1'b0}}, op} * {{S{1'b0}}, op};
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
    if (cmd_i.store_root) root_q  <= sq_root;
    if (cmd_i.cmp_a)      thrdt_q <= TD_W'(thr_q) * TD_W'(dt);
    if (cmd_i.out_load) begin
      out_sampled_q <= sampled_q;
      out_failed_q  <= failed_q;
      out_mag_q     <= held_mag_q;
      out_jerk_q    <= held_jerk_q;
      out_over_q    <= en_q & held_over_q;
    end
  end

  assign stat_o.enable    = en_q;
  assign stat_o.due       = DUE_W'(dt) >= DUE_W'(period_q);
  assign stat_o.read_ok   = ok_q;
  assign stat_o.hist      = (last_time_q != '0) && (t_q > last_time_q);
  assign stat_o.sqrt_busy = sq_busy;
  assign stat_o.sqrt_done = sq_done;
  assign stat_o.div_done  = dv_done;

  assign sampled_o        = out_sampled_q;
  assign read_failed_o    = out_failed_q;
  assign magnitude_o      = out_mag_q;
  assign jerk_o           = out_jerk_q;
  assign over_threshold_o = out_over_q;

endmodule

/* design/ajm_ctrl.sv */
// ----------------------------------------------------------------------------
// ajm_ctrl
// Sequencer for one tick: decide, square and root, divide, hand off result.
// ----------------------------------------------------------------------------
module ajm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ajm_pkg::ajm_stat_t  stat_i,
  output ajm_pkg::ajm_cmd_t   cmd_o
);

  ajm_pkg::ajm_state_e             state_q, state_d;
  logic [ajm_pkg::SQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ajm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ajm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ajm_pkg::ST_DECIDE;
        end
      end
      ajm_pkg::ST_DECIDE: begin
        cnt_d = '0;
        if (!stat_i.enable) begin
          cmd_o.clear_hist = 1'b1;
          state_d          = ajm_pkg::ST_FINISH;
        end else if (!stat_i.due) begin
          state_d = ajm_pkg::ST_FINISH;
        end else if (!stat_i.read_ok) begin
          cmd_o.take_fail = 1'b1;
          state_d         = ajm_pkg::ST_FINISH;
        end else begin
          cmd_o.set_sampled = 1'b1;
          state_d           = ajm_pkg::ST_MAG_SQ;
        end
      end
      ajm_pkg::ST_MAG_SQ, ajm_pkg::ST_DIF_SQ: begin
        // three squares through one multiplier, each accumulated in the cycle after it is formed
        cmd_o.sq_diff = (state_q == ajm_pkg::ST_DIF_SQ);
        cmd_o.sq_sel  = cnt_q[1:0];
        cmd_o.acc_clr = (cnt_q == '0);
        cmd_o.mul_en  = (cnt_q < ajm_pkg::SQ_ACC_LAST);
        cmd_o.acc_en  = (cnt_q != '0) && (cnt_q <= ajm_pkg::SQ_ACC_LAST);
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == ajm_pkg::SQ_ROOT) begin
          cmd_o.sqrt_start = 1'b1;
          cnt_d            = '0;
          state_d          = (state_q == ajm_pkg::ST_DIF_SQ) ? ajm_pkg::ST_DIF_WAIT
                                                             : ajm_pkg::ST_MAG_WAIT;
        end
      end
      ajm_pkg::ST_MAG_WAIT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.store_mag = 1'b1;
          if (stat_i.hist) begin
            state_d = ajm_pkg::ST_DIF_SQ;
          end else begin
            cmd_o.zero_jerk = 1'b1;
            cmd_o.commit    = 1'b1;
            state_d         = ajm_pkg::ST_FINISH;
          end
        end
      end
      ajm_pkg::ST_DIF_WAIT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.store_root = 1'b1;
          state_d          = ajm_pkg::ST_OVR_A;
        end
      end
      ajm_pkg::ST_OVR_A: begin
        cmd_o.cmp_a     = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ajm_pkg::ST_OVR_B;
      end
      ajm_pkg::ST_OVR_B: begin
        cmd_o.cmp_b = 1'b1;
        state_d     = ajm_pkg::ST_DIV_WAIT;
      end
      ajm_pkg::ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.store_jerk = 1'b1;
          cmd_o.commit     = 1'b1;
          state_d          = ajm_pkg::ST_FINISH;
        end
      end
      ajm_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ajm_pkg::ST_IDLE;
        end
      end
      default: state_d = ajm_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten while pending");

  a_sqrt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sqrt_start |-> !stat_i.sqrt_busy)
    else $error("root started while busy");

  a_div_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> stat_i.hist)
    else $error("divide started without history");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ajm_pkg::ST_DECIDE))
    else $error("accepted word not decided next cycle");

endmodule

/* sim/ajm_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajm_result_checker
// Tracks the monitor's config writes and accepted tick words and predicts each
// tick's sampled and failed flags, held magnitude, jerk and over-threshold flag.
// Every result word is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module ajm_result_checker #(
  parameter int TIME_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ajm_in_if                              in_mon,
  ajm_out_if                             out_mon,
  input  logic                           cfg_we_i,
  input  logic [ajm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ajm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             ticks_o,
  output int                             samples_o,
  output int                             fails_o,
  output int                             overs_o
);
  import ajm_pkg::*;

  typedef struct packed {
    logic              sampled;
    logic              read_failed;
    logic [MAG_W-1:0]  magnitude;
    logic [JERK_W-1:0] jerk;
    logic              over_threshold;
  } tick_result_t;

  logic                          en_q;
  logic [PERIOD_W-1:0]           period_q;
  logic [THR_W-1:0]              thr_q;
  logic [TIME_BITS-1:0]          last_time_q;
  logic signed [SAMPLE_BITS-1:0] last_x_q;
  logic signed [SAMPLE_BITS-1:0] last_y_q;
  logic signed [SAMPLE_BITS-1:0] last_z_q;
  logic [MAG_W-1:0]              mag_q;
  logic [JERK_W-1:0]             jerk_q;
  logic                          over_q;

  tick_result_t held_results_q[$];
  int mismatches = 0;
  int n_ticks    = 0;
  int n_samples  = 0;
  int n_fails    = 0;
  int n_overs    = 0;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sum_sq(input longint a, input longint b,
                                             input longint c);
    return longint'(a * a + b * b + c * c);
  endfunction

  task automatic clear_history();
    last_time_q = '0;
    last_x_q    = '0;
    last_y_q    = '0;
    last_z_q    = '0;
    mag_q       = '0;
    jerk_q      = '0;
    over_q      = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("checker: %s mismatch at result %0d: got %0h want %0h",
             what, n_ticks, got, want);
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENABLE: begin
        en_q = data[0];
        if (!data[0]) clear_history();
      end
      CFG_PERIOD:    period_q = data[PERIOD_W-1:0];
      CFG_THRESHOLD: thr_q = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_held_values(input logic [TIME_BITS-1:0] t,
                                     input logic signed [SAMPLE_BITS-1:0] x,
                                     input logic signed [SAMPLE_BITS-1:0] y,
                                     input logic signed [SAMPLE_BITS-1:0] z,
                                     input logic ok);
    tick_result_t r;
    logic [TIME_BITS-1:0] gap;
    longint unsigned root;
    longint unsigned dt;
    r   = '0;
    gap = t - last_time_q;
    if (!en_q) begin
      clear_history();
    end else if (gap >= period_q) begin
      if (!ok) begin
        r.read_failed = 1'b1;
        last_time_q   = t;
      end else begin
        r.sampled = 1'b1;
        mag_q = MAG_W'(floor_sqrt(sum_sq(longint'(x), longint'(y), longint'(z))));
        if (last_time_q != 0 && t > last_time_q) begin
          dt   = longint'(t) - longint'(last_time_q);
          root = floor_sqrt(sum_sq(longint'(x) - longint'(last_x_q),
                                   longint'(y) - longint'(last_y_q),
                                   longint'(z) - longint'(last_z_q)));
          jerk_q = JERK_W'((root << FRAC_BITS) / dt);
          over_q = (root * JERK_SCALE) > ((longint'(thr_q) << G_SHIFT) * dt);
        end else begin
          jerk_q = '0;
          over_q = 1'b0;
        end
        last_x_q    = x;
        last_y_q    = y;
        last_z_q    = z;
        last_time_q = t;
      end
    end
    r.magnitude      = mag_q;
    r.jerk           = jerk_q;
    r.over_threshold = en_q & over_q;
    held_results_q.push_back(r);
  endtask

  task automatic check_result();
    tick_result_t e;
    if (held_results_q.size() == 0) begin
      report_mismatch("unexpected word", 32'd1, 32'd0);
    end else begin
      e = held_results_q.pop_front();
      if (out_mon.sampled !== e.sampled)
        report_mismatch("sampled", 32'(out_mon.sampled), 32'(e.sampled));
      if (out_mon.read_failed !== e.read_failed)
        report_mismatch("read_failed", 32'(out_mon.read_failed), 32'(e.read_failed));
      if (out_mon.magnitude !== e.magnitude)
        report_mismatch("magnitude", 32'(out_mon.magnitude), 32'(e.magnitude));
      if (out_mon.jerk !== e.jerk)
        report_mismatch("jerk", 32'(out_mon.jerk), 32'(e.jerk));
      if (out_mon.over_threshold !== e.over_threshold)
        report_mismatch("over_threshold", 32'(out_mon.over_threshold),
                        32'(e.over_threshold));
      n_samples += e.sampled;
      n_fails   += e.read_failed;
      n_overs   += e.over_threshold;
    end
    n_ticks++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     = 1'b0;
      period_q = PERIOD_RESET;
      thr_q    = '0;
      clear_history();
      held_results_q.delete();
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (in_mon.valid && in_mon.ready)
        predict_held_values(in_mon.time_ms, in_mon.raw_x, in_mon.raw_y, in_mon.raw_z,
                            in_mon.read_ok);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    fail_count_o <= mismatches;
    pending_o    <= held_results_q.size();
    ticks_o      <= n_ticks;
    samples_o    <= n_samples;
    fails_o      <= n_fails;
    overs_o      <= n_overs;
  end

endmodule

/* sim/tb_accel_jerk_magnitude_monitor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_jerk_magnitude_monitor_unit
// Drives tick words and config writes into the magnitude and jerk monitor:
// a directed pass over extremes, wrap and no-history cases, then random
// phases under several configs with bursty stalls on both channels.
// ----------------------------------------------------------------------------
module tb_accel_jerk_magnitude_monitor_unit;
  import ajm_pkg::*;

  localparam int SAMPLE_BITS    = 16;
  localparam int TIME_BITS      = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED = 2'd3;
  localparam logic [SAMPLE_BITS-1:0] AX_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] AX_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic idle_on   = 1'b1;
  logic hold_req  = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  logic [TIME_BITS-1:0]          tick_time = '0;
  logic signed [SAMPLE_BITS-1:0] axis [3];

  int fail_count, pending, ticks, samples, fails, overs;

  ajm_in_if #(.TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  ajm_out_if out_if ();

  accel_jerk_magnitude_monitor_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  ajm_result_checker #(
    .TIME_BITS  (TIME_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .ticks_o     (ticks),
    .samples_o   (samples),
    .fails_o     (fails),
    .overs_o     (overs)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: one long hold-off on request, else short random stalls while idle_on is set
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_tick(input logic [TIME_BITS-1:0] t,
                           input logic signed [SAMPLE_BITS-1:0] x,
                           input logic signed [SAMPLE_BITS-1:0] y,
                           input logic signed [SAMPLE_BITS-1:0] z,
                           input logic ok);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.time_ms <= t;
    in_if.raw_x   <= x;
    in_if.raw_y   <= y;
    in_if.raw_z   <= z;
    in_if.read_ok <= ok;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_config(input logic en, input logic [PERIOD_W-1:0] period,
                            input logic [THR_W-1:0] thr);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ENABLE;
    cfg_data_i <= {15'($urandom), en};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PERIOD;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_THRESHOLD;
    cfg_data_i <= {8'($urandom), thr};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UNUSED;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly time steps in range with drifting readings, some noise
  task automatic run_random(input int n, input int step_lo, input int step_hi);
    int roll;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85)
        tick_time = tick_time + TIME_BITS'($urandom_range(step_lo, step_hi));
      else
        tick_time = TIME_BITS'($urandom);
      for (int a = 0; a < 3; a++) begin
        roll = $urandom_range(0, 99);
        if (roll < 60)
          axis[a] = axis[a] + SAMPLE_BITS'(int'($urandom_range(0, 6000)) - 3000);
        else if (roll < 85)
          axis[a] = SAMPLE_BITS'($urandom);
        else if (roll < 90)
          axis[a] = AX_MIN;
        else if (roll < 95)
          axis[a] = AX_MAX;
        else
          axis[a] = '0;
      end
      send_tick(tick_time, axis[0], axis[1], axis[2], $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ENABLE;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.time_ms = '0;
    in_if.raw_x   = '0;
    in_if.raw_y   = '0;
    in_if.raw_z   = '0;
    in_if.read_ok = 1'b0;
    axis[0] = '0;
    axis[1] = '0;
    axis[2] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset
    send_tick(16'd0, AX_MIN, AX_MIN, AX_MIN, 1'b1);
    send_tick(16'hFFFF, AX_MAX, AX_MAX, AX_MAX, 1'b0);

    set_config(1'b1, 16'd0, 8'd255);
    send_tick(16'd0, AX_MIN, AX_MIN, AX_MIN, 1'b1);
    send_tick(16'd1, AX_MAX, AX_MAX, AX_MAX, 1'b1);
    send_tick(16'd2, AX_MIN, AX_MIN, AX_MIN, 1'b1);
    send_tick(16'd2, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd3, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'd1, 16'sd100, -16'sd100, 16'sd50, 1'b1);
    send_tick(16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd0, AX_MAX, 16'sd0, AX_MIN, 1'b1);
    send_tick(16'd5, 16'sd0, AX_MAX, 16'sd0, 1'b1);

    set_config(1'b1, 16'hFFFF, 8'd0);
    send_tick(16'd6, 16'sd1, 16'sd1, 16'sd1, 1'b1);
    send_tick(16'd4, 16'sd7, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd3, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_tick(16'd2, 16'sd1, 16'sd0, 16'sd0, 1'b1);

    set_config(1'b1, 16'd50, 8'd0);
    send_tick(16'd52, 16'sd2049, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd60, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd102, 16'sd2049, 16'sd0, 16'sd0, 1'b1);

    set_config(1'b0, 16'd50, 8'd0);
    send_tick(16'd200, AX_MAX, AX_MIN, AX_MAX, 1'b1);

    // threshold boundary: 2621 stays under, 2622 goes over
    set_config(1'b1, 16'd10, 8'd128);
    send_tick(16'd210, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd220, 16'sd2621, 16'sd0, 16'sd0, 1'b1);
    send_tick(16'd230, 16'sd5243, 16'sd0, 16'sd0, 1'b1);

    set_config(1'b1, PERIOD_W'($urandom_range(1, 20)), THR_W'($urandom_range(0, 255)));
    run_random(100, 0, 25);

    set_config(1'b1, 16'd0, 8'd0);
    hold_req <= 1'b1;
    run_random(60, 0, 3);

    set_config(1'b0, PERIOD_W'($urandom), THR_W'($urandom));
    run_random(30, 0, 60);

    set_config(1'b1, 16'hFFFF, 8'd255);
    run_random(40, 65535, 65535);

    set_config(1'b1, PERIOD_W'($urandom_range(30, 80)), THR_W'($urandom_range(0, 255)));
    run_random(100, 0, 100);

    idle_on <= 1'b0;
    set_config(1'b1, 16'd5, THR_W'($urandom_range(0, 255)));
    run_random(120, 0, 10);

    drain();
    repeat (100) @(posedge clk_i);

    $display("summary: %0d ticks checked, %0d good samples, %0d failed reads,",
             ticks, samples, fails);
    $display("summary: %0d over-threshold results across 11 config settings", overs);
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
